// ===== rtl/core/rlcrw_pkg.sv =====
// Package for the receive reordering window: widths, payload structs and codes.
// No dependencies.
package rlcrw_pkg;

  localparam int unsigned WindowDepth = 32;
  localparam int unsigned SeqBits     = 32;
  localparam int unsigned OffW        = $clog2(WindowDepth);
  localparam int unsigned WinW        = 6;
  localparam int unsigned TmoW        = 16;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned QDepth      = 2;

  localparam logic [CfgIdxW-1:0] CfgWindowSize = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeout    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFirstBase  = 2'd2;

  typedef enum logic [2:0] {
    KindReleased  = 3'd0,
    KindDuplicate = 3'd1,
    KindTooOld    = 3'd2,
    KindAccepted  = 3'd3,
    KindTick      = 3'd4
  } kind_e;

  typedef struct packed {
    logic              cmd;
    logic [SeqBits-1:0] seq_num;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [SeqBits-1:0] out_seq;
    logic               last;
  } out_item_t;

endpackage

// ===== rtl/core/rlcrw_queue.sv =====
// Two-entry queue of input items between the front and the window engine.
// Depends on rlcrw_pkg.
module rlcrw_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rlcrw_pkg::in_item_t data_i,
  output logic               full_o,
  output logic               empty_o,
  input  logic               pop_i,
  output rlcrw_pkg::in_item_t data_o
);
  import rlcrw_pkg::*;

  in_item_t mem_q [QDepth];
  logic rd_q, rd_d, wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'(QDepth));
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    rd_d  = rd_q;
    wr_d  = wr_q;
    cnt_d = cnt_q;
    if (push_i && !full_o) begin
      wr_d  = ~wr_q;
      cnt_d = cnt_d + 2'd1;
    end
    if (pop_i && !empty_o) begin
      rd_d  = ~rd_q;
      cnt_d = cnt_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= data_i;
    end
  end
endmodule

// ===== rtl/core/rlcrw_engine.sv =====
// Window engine: classifies one item, scans the bitmap one entry a cycle while
// no release stalls, emits via one-entry output register. Depends on rlcrw_pkg.
module rlcrw_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [rlcrw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rlcrw_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                  item_valid_i,
  input  rlcrw_pkg::in_item_t   item_i,
  output logic                  item_take_o,
  output logic                  res_valid_o,
  output rlcrw_pkg::out_item_t  res_o,
  input  logic                  res_pop_i
);
  import rlcrw_pkg::*;

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StDecide= 6'b000010,
    StSlide = 6'b000100,
    StMark  = 6'b001000,
    StRun   = 6'b010000,
    StFinish= 6'b100000
  } state_e;

  localparam logic [SeqBits-1:0] SeqTop = '1;

  state_e state_q, state_d;
  logic [WinW-1:0]  win_q, win_d;
  logic [TmoW-1:0]  tmo_q, tmo_d;
  logic             fpb_q, fpb_d;
  logic [WindowDepth-1:0] bm_q, bm_d;
  logic [SeqBits-1:0] base_q, base_d, rn_q, rn_d, hn_q, hn_d, mark_q, mark_d;
  logic             trun_q, trun_d, taken_q, taken_d;
  logic [TmoW-1:0]  tcnt_q, tcnt_d;
  in_item_t         it_q, it_d;
  logic             tick_q, tick_d;
  logic [SeqBits-1:0] cnt_q, cnt_d;   // slide count remaining
  logic             emitted_q, emitted_d;
  logic             ov_q, ov_d;
  out_item_t        ov_data_q, ov_data_d;
  out_item_t        pend_q, pend_d;   // newest release, held until the next one

  logic [SeqBits:0] eff_w;
  logic             can_emit, rel_ok;
  logic [SeqBits-1:0] off_rn, off_tsn, slide_len, step;
  logic             rn_in, tsn_in, rn_bit, tsn_bit;
  logic [SeqBits-1:0] tgt;

  always_comb begin
    if (win_q == '0) eff_w = (SeqBits+1)'(1);
    else if (win_q > WinW'(WindowDepth)) eff_w = (SeqBits+1)'(WindowDepth);
    else eff_w = (SeqBits+1)'(win_q);
  end

  assign off_rn  = rn_q - base_q;
  assign rn_in   = (rn_q >= base_q) && (off_rn < SeqBits'(WindowDepth));
  assign rn_bit  = rn_in && bm_q[off_rn[OffW-1:0]];
  assign off_tsn = it_q.seq_num - base_q;
  assign tsn_in  = (it_q.seq_num >= base_q) && (off_tsn < SeqBits'(WindowDepth));
  assign tsn_bit = tsn_in && bm_q[off_tsn[OffW-1:0]];
  assign tgt     = (mark_q < hn_q) ? mark_q : hn_q;
  assign can_emit = !ov_q || res_pop_i;
  // a release needs the output register only when an older one is pending
  assign rel_ok   = !emitted_q || can_emit;
  assign item_take_o = (state_q == StIdle) && item_valid_i;
  assign res_valid_o = ov_q;
  assign res_o       = ov_data_q;
  // slide: d = min(s, tsn - base), s = tsn+1-old highest
  assign step = it_q.seq_num + SeqBits'(1) - hn_q;
  assign slide_len = (step < off_tsn) ? step : off_tsn;

  always_comb begin
    state_d = state_q; win_d = win_q; tmo_d = tmo_q; fpb_d = fpb_q;
    bm_d = bm_q; base_d = base_q; rn_d = rn_q; hn_d = hn_q; mark_d = mark_q;
    trun_d = trun_q; taken_d = taken_q; tcnt_d = tcnt_q; it_d = it_q;
    tick_d = tick_q; cnt_d = cnt_q; emitted_d = emitted_q;
    ov_d = ov_q; ov_data_d = ov_data_q; pend_d = pend_q;
    if (ov_q && res_pop_i) ov_d = 1'b0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWindowSize: win_d = cfg_data_i[WinW-1:0];
        CfgTimeout:    tmo_d = cfg_data_i[TmoW-1:0];
        CfgFirstBase:  fpb_d = cfg_data_i[0];
        default: ;
      endcase
    end

    case (state_q)
      StIdle: begin
        if (item_valid_i) begin
          it_d = item_i;
          emitted_d = 1'b0;
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (it_q.cmd) begin
          // timer tick
          if (!trun_q) begin
            if (can_emit) begin
              ov_d = 1'b1; ov_data_d = '{3'(KindTick), '0, 1'b1};
              state_d = StIdle;
            end
          end else if (tcnt_q > TmoW'(1)) begin
            if (can_emit) begin
              tcnt_d = tcnt_q - TmoW'(1);
              ov_d = 1'b1; ov_data_d = '{3'(KindTick), '0, 1'b1};
              state_d = StIdle;
            end
          end else begin
            trun_d = 1'b0; tcnt_d = '0; tick_d = 1'b1;
            state_d = StRun;
          end
        end else if (it_q.seq_num == SeqTop) begin
          if (can_emit) begin
            ov_d = 1'b1; ov_data_d = '{3'(KindTooOld), it_q.seq_num, 1'b1};
            state_d = StIdle;
          end
        end else if (fpb_q && !taken_q) begin
          bm_d = '0; base_d = it_q.seq_num; rn_d = it_q.seq_num;
          hn_d = it_q.seq_num; mark_d = it_q.seq_num;
          win_d = WinW'(1); taken_d = 1'b1;
        end else if (it_q.seq_num >= rn_q && it_q.seq_num < hn_q && tsn_bit) begin
          if (can_emit) begin
            ov_d = 1'b1; ov_data_d = '{3'(KindDuplicate), it_q.seq_num, 1'b1};
            state_d = StIdle;
          end
        end else if (it_q.seq_num < rn_q) begin
          if (can_emit) begin
            ov_d = 1'b1; ov_data_d = '{3'(KindTooOld), it_q.seq_num, 1'b1};
            state_d = StIdle;
          end
        end else begin
          tick_d = 1'b0;
          state_d = StMark;
          if (it_q.seq_num >= hn_q) begin
            hn_d = it_q.seq_num + SeqBits'(1);
            if ({1'b0, base_q} + eff_w < {1'b0, it_q.seq_num} + (SeqBits+1)'(1)) begin
              cnt_d = (it_q.seq_num >= base_q) ? slide_len : '0;
              state_d = StSlide;
            end
          end
        end
      end
      StSlide: begin
        // shift window one position per cycle, releasing bit 0 (held while a
        // release waits); jump the rest in one step once the bitmap is empty
        if (cnt_q == '0) begin
          if (rn_q < base_q) rn_d = base_q;
          state_d = StMark;
        end else if (bm_q == '0) begin
          base_d = base_q + cnt_q;
          cnt_d = '0;
        end else if (!bm_q[0] || rel_ok) begin
          if (bm_q[0]) begin
            if (emitted_q) begin
              ov_d = 1'b1; ov_data_d = pend_q;
            end
            pend_d = '{3'(KindReleased), base_q, 1'b0};
            emitted_d = 1'b1;
          end
          bm_d = bm_q >> 1;
          base_d = base_q + SeqBits'(1);
          cnt_d = cnt_q - SeqBits'(1);
        end
      end
      StMark: begin
        if (tsn_in) bm_d[off_tsn[OffW-1:0]] = 1'b1;
        state_d = StRun;
      end
      StRun: begin
        // on expiry sweep up to the timer mark first, releasing entries
        // received past the gaps; then release the in-order run
        if (tick_q && rn_q < tgt && !rn_in) begin
          rn_d = tgt;
        end else if (tick_q && rn_q < tgt && !rn_bit) begin
          rn_d = rn_q + SeqBits'(1);
        end else if ((tick_q ? (rn_q < hn_q) : (rn_q != hn_q)) && rn_bit) begin
          if (rel_ok) begin
            if (emitted_q) begin
              ov_d = 1'b1; ov_data_d = pend_q;
            end
            pend_d = '{3'(KindReleased), rn_q, 1'b0};
            emitted_d = 1'b1;
            bm_d[off_rn[OffW-1:0]] = 1'b0;
            rn_d = rn_q + SeqBits'(1);
          end
        end else begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (can_emit) begin
          if (!tick_q && trun_q &&
              (mark_q <= rn_q || mark_q < base_q || mark_q > hn_q)) begin
            trun_d = 1'b0;
          end
          if ((tick_q || !trun_d) && hn_q > rn_q) begin
            trun_d = 1'b1; tcnt_d = tmo_q; mark_d = hn_q;
          end
          ov_d = 1'b1;
          if (emitted_q) begin
            // the pending release is the last one; mark it
            ov_data_d = pend_q;
            ov_data_d.last = 1'b1;
          end else begin
            ov_data_d = tick_q ? '{3'(KindTick), '0, 1'b1}
                               : '{3'(KindAccepted), it_q.seq_num, 1'b1};
          end
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; win_q <= WinW'(32); tmo_q <= TmoW'(50); fpb_q <= 1'b0;
      bm_q <= '0; base_q <= '0; rn_q <= '0; hn_q <= '0; mark_q <= '0;
      trun_q <= 1'b0; taken_q <= 1'b0; tcnt_q <= '0; ov_q <= 1'b0;
      emitted_q <= 1'b0; tick_q <= 1'b0;
    end else begin
      state_q <= state_d; win_q <= win_d; tmo_q <= tmo_d; fpb_q <= fpb_d;
      bm_q <= bm_d; base_q <= base_d; rn_q <= rn_d; hn_q <= hn_d; mark_q <= mark_d;
      trun_q <= trun_d; taken_q <= taken_d; tcnt_q <= tcnt_d; ov_q <= ov_d;
      emitted_q <= emitted_d; tick_q <= tick_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q <= it_d; cnt_q <= cnt_d; ov_data_q <= ov_data_d; pend_q <= pend_d;
  end
endmodule

// ===== rtl/core/rlc_um_rx_reorder_window.sv =====
// Top level of the receive reordering window: input queue plus window engine.
// Depends on rlcrw_pkg, rlcrw_queue and rlcrw_engine.
//
// Channel  | direction | handshake  | payload
// input    | in        | push/full  | in_data_i  (cmd, seq_num)
// result   | out       | pop/empty  | out_data_o (kind, out_seq, last)
// config   | in        | cfg_we_i   | cfg_idx_i, cfg_data_i
//
// A dropped item or idle tick is answered in StDecide; an accepted item
// passes StDecide, StMark, StRun and StFinish. The engine also steps once
// per window position slid, per entry scanned on expiry and per entry
// released; a slide over an empty bitmap jumps in one step.
// Reset is asynchronous and active low.
// A result waits in the output register; while it is not taken the engine
// holds at its next transfer; the input queue takes items until it is full.
module rlc_um_rx_reorder_window (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rlcrw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [rlcrw_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  rlcrw_pkg::in_item_t            in_data_i,
  output logic                           empty,
  input  logic                           pop,
  output rlcrw_pkg::out_item_t           out_data_o
);
  import rlcrw_pkg::*;

  logic     q_empty, take, res_valid;
  in_item_t q_data;

  // Front: buffer up to two arriving items while the engine scans.
  rlcrw_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (push), .data_i (in_data_i), .full_o (full),
    .empty_o(q_empty), .pop_i (take), .data_o (q_data)
  );

  // Back: classify, slide, release; one result register to the sink.
  rlcrw_engine u_engine (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .item_valid_i(!q_empty), .item_i(q_data), .item_take_o(take),
    .res_valid_o(res_valid), .res_o(out_data_o), .res_pop_i(pop)
  );

  assign empty = !res_valid;
endmodule

// ===== dv/tb.sv =====
// Testbench for the receive reordering window: directed and random PDU arrivals and
// timer ticks, checked against an in-bench prediction of the window.
// Depends on rlcrw_pkg and rlc_um_rx_reorder_window.
`timescale 1ns / 1ps

module tb;
  import rlcrw_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainWait  = 80;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                push;
  logic                full;
  in_item_t            in_data;
  logic                empty;
  logic                pop;
  out_item_t           out_data;

  rlc_um_rx_reorder_window dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data)
  );

  always #1 clk = ~clk;

  // Predicted window state; 64-bit counters so that highest_next never wraps.
  bit [WindowDepth-1:0] rcv_map;
  longint unsigned      win_base, reo_next, hi_next, t_mark, t_cnt;
  bit                   t_run, base_set;
  longint unsigned      cfg_win, cfg_tmo;
  bit                   cfg_first;

  out_item_t            expected_q[$];
  int                   n_emitted;
  int                   errors;
  bit                   gaps_on;
  int unsigned          quiet_cycles;

  function automatic void emit_result(kind_e k, longint unsigned s);
    out_item_t r;
    r.kind    = k;
    r.out_seq = s[SeqBits-1:0];
    r.last    = 1'b0;
    expected_q.push_back(r);
    n_emitted++;
  endfunction

  function automatic longint unsigned eff_window();
    if (cfg_win == 0) return 1;
    if (cfg_win > WindowDepth) return WindowDepth;
    return cfg_win;
  endfunction

  function automatic bit received(longint unsigned s);
    if (s < win_base || s - win_base >= WindowDepth) return 1'b0;
    return rcv_map[s - win_base];
  endfunction

  // Release received entries at offsets [lo, hi) from the window base.
  function automatic void release_span(longint unsigned lo, longint unsigned hi);
    longint unsigned off;
    if (hi > WindowDepth) hi = WindowDepth;
    for (off = lo; off < hi; off++) begin
      if (rcv_map[off]) begin
        emit_result(KindReleased, win_base + off);
        rcv_map[off] = 1'b0;
      end
    end
  endfunction

  function automatic void arm_timer();
    t_run  = 1'b1;
    t_cnt  = cfg_tmo;
    t_mark = hi_next;
  endfunction

  function automatic void pdu_arrival(longint unsigned tsn);
    longint unsigned prev, step, d;
    if (tsn == 64'hFFFF_FFFF) begin
      emit_result(KindTooOld, tsn);
      return;
    end
    // Multicast start: first PDU pins the window and forces its length to one.
    if (cfg_first && !base_set) begin
      rcv_map  = '0;
      win_base = tsn;
      reo_next = tsn;
      hi_next  = tsn;
      t_mark   = tsn;
      cfg_win  = 1;
      base_set = 1'b1;
    end
    if (tsn >= reo_next && tsn < hi_next && received(tsn)) begin
      emit_result(KindDuplicate, tsn);
      return;
    end
    if (tsn < reo_next) begin
      emit_result(KindTooOld, tsn);
      return;
    end
    if (tsn >= hi_next) begin
      prev    = hi_next;
      hi_next = tsn + 1;
      if (win_base + eff_window() < hi_next) begin
        step = hi_next - prev;
        d    = 0;
        if (tsn >= win_base) d = (step < tsn - win_base) ? step : tsn - win_base;
        release_span(0, d);
        rcv_map  = (d >= WindowDepth) ? '0 : rcv_map >> d;
        win_base += d;
        if (reo_next < win_base) reo_next = win_base;
      end
    end
    if (tsn >= win_base && tsn - win_base < WindowDepth) rcv_map[tsn - win_base] = 1'b1;
    if (received(reo_next)) begin
      prev = reo_next;
      while (received(reo_next)) begin
        reo_next++;
        if (reo_next == hi_next) break;
      end
      if (prev >= win_base) release_span(prev - win_base, reo_next - win_base);
    end
    if (t_run && (t_mark <= reo_next || t_mark < win_base || t_mark > hi_next)) t_run = 1'b0;
    if (!t_run && hi_next > reo_next) arm_timer();
    if (n_emitted == 0) emit_result(KindAccepted, tsn);
  endfunction

  function automatic void timer_tick();
    longint unsigned prev, target;
    if (!t_run) begin
      emit_result(KindTick, 0);
      return;
    end
    if (t_cnt > 1) begin
      t_cnt--;
      emit_result(KindTick, 0);
      return;
    end
    t_run = 1'b0;
    t_cnt = 0;
    // Expiry: skip gaps up to the mark, then release up to the next gap.
    prev   = reo_next;
    target = (t_mark < hi_next) ? t_mark : hi_next;
    if (reo_next < target) reo_next = target;
    while (reo_next < hi_next && received(reo_next)) reo_next++;
    if (prev >= win_base) release_span(prev - win_base, reo_next - win_base);
    if (hi_next > reo_next) arm_timer();
    if (n_emitted == 0) emit_result(KindTick, 0);
  endfunction

  function automatic void predict_window(in_item_t it);
    n_emitted = 0;
    if (it.cmd == 1'b0) pdu_arrival(longint'(it.seq_num));
    else timer_tick();
    expected_q[expected_q.size()-1].last = 1'b1;
  endfunction

  // Drive one item from a falling edge, hold it until the transfer, return at a falling edge.
  task automatic send_item(bit is_tick, longint unsigned s);
    in_item_t it;
    it.cmd     = is_tick;
    it.seq_num = s[SeqBits-1:0];
    while (gaps_on && $urandom_range(0, 99) < 37) begin
      push = 1'b0;
      @(negedge clk);
    end
    push    = 1'b1;
    in_data = it;
    do @(posedge clk); while (full);
    predict_window(it);
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic send_pdu(longint unsigned s);
    send_item(1'b0, s);
  endtask

  task automatic send_tick();
    send_item(1'b1, longint'($urandom));
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  // Write one register; only called with the window idle.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned val);
    wait_drained();
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val[CfgDataW-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CfgWindowSize: cfg_win   = val & 'h3F;
      CfgTimeout:    cfg_tmo   = val & 'hFFFF;
      CfgFirstBase:  cfg_first = val[0];
      default: ;
    endcase
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_tick();
  endtask

  // In-order, gap, duplicate, too old, and the timer skipping a gap.
  task automatic test_basic_order();
    write_reg(CfgTimeout, 3);
    send_pdu(0);
    send_pdu(1);
    send_pdu(3);
    send_pdu(3);
    send_pdu(2);
    send_pdu(0);
    send_pdu(6);
    send_pdu(8);
    send_ticks(4);
    send_pdu(5);
  endtask

  // Zero timeout expires on the first tick; the largest timeout only counts.
  task automatic test_timeout_extremes();
    write_reg(CfgTimeout, 0);
    send_pdu(hi_next + 2);
    send_tick();
    write_reg(CfgTimeout, 65535);
    send_pdu(hi_next + 3);
    send_ticks(2);
    send_tick();
  endtask

  // Out-of-range window lengths, then a jump far beyond the built depth.
  task automatic test_window_extremes();
    write_reg(CfgWindowSize, 0);
    send_pdu(hi_next + 1);
    send_pdu(hi_next + 2);
    write_reg(CfgWindowSize, 63);
    send_pdu(hi_next + 40);
    send_pdu(hi_next - 5);
    write_reg(CfgWindowSize, 1);
    send_pdu(hi_next + 3);
    write_reg(CfgWindowSize, 32);
    send_pdu(hi_next + 500);
    send_pdu(hi_next + 1);
  endtask

  function automatic longint unsigned pick_seq();
    int unsigned r;
    longint unsigned lo;
    r  = $urandom_range(0, 99);
    lo = (reo_next > 2) ? reo_next - 2 : 0;
    if (r < 70) return lo + $urandom_range(0, int'(hi_next - lo) + int'(eff_window()));
    if (r < 85) return hi_next + $urandom_range(0, 3);
    return hi_next + $urandom_range(0, 300);
  endfunction

  task automatic random_phase(int n, bit with_pause);
    int i;
    for (i = 0; i < n; i++) begin
      if (with_pause && i == n / 2) wait_drained();
      if ($urandom_range(0, 99) < 25) send_tick();
      else send_pdu(pick_seq());
    end
  endtask

  task automatic test_random_settings();
    write_reg(CfgWindowSize, $urandom_range(4, 16));
    write_reg(CfgTimeout, $urandom_range(1, 4));
    random_phase(30, 1'b1);
    gaps_on = 1'b0;
    write_reg(CfgWindowSize, 32);
    write_reg(CfgTimeout, 1);
    random_phase(30, 1'b0);
    gaps_on = 1'b1;
    write_reg(CfgWindowSize, $urandom_range(1, 32));
    write_reg(CfgTimeout, $urandom_range(2, 6));
    random_phase(30, 1'b0);
  endtask

  // Multicast: the first PDU after the write pins the base; window drops to one.
  task automatic test_multicast_start();
    write_reg(CfgFirstBase, 1);
    send_pdu(hi_next + 1000);
    send_pdu(hi_next + 2);
    send_pdu(hi_next);
    send_ticks(3);
    write_reg(CfgFirstBase, 0);
    write_reg(CfgWindowSize, 20);
    random_phase(30, 1'b0);
  endtask

  // Top of the number space, then a final leap near it; nothing useful follows.
  task automatic test_top_numbers();
    send_pdu(64'hFFFF_FFFF);
    send_pdu(64'h5555_5555);
    send_pdu(64'hAAAA_AAAA);
    send_pdu(64'hFFFF_FFFE);
    send_pdu(64'hFFFF_FFFF);
    send_pdu(0);
    send_tick();
  endtask

  // Pop side: stall at random while gaps are on.
  always @(negedge clk) begin
    if (rst_n) pop <= !gaps_on || ($urandom_range(0, 99) >= 37);
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind=%0d seq=%0h last=%0b", $time,
                 out_data.kind, out_data.out_seq, out_data.last);
        errors++;
      end else begin
        if (out_data !== expected_q[0]) begin
          $display("%0t: mismatch expected kind=%0d seq=%0h last=%0b", $time,
                   expected_q[0].kind, expected_q[0].out_seq, expected_q[0].last);
          $display("%0t:          actual   kind=%0d seq=%0h last=%0b", $time,
                   out_data.kind, out_data.out_seq, out_data.last);
          errors++;
        end
        void'(expected_q.pop_front());
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL rlc_um_rx_reorder_window");
      $finish;
    end
  end

  initial begin
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    push     = 1'b0;
    in_data  = '0;
    pop      = 1'b0;
    gaps_on  = 1'b1;
    errors   = 0;
    quiet_cycles = 0;
    rcv_map  = '0;
    win_base = 0;
    reo_next = 0;
    hi_next  = 0;
    t_mark   = 0;
    t_cnt    = 0;
    t_run    = 1'b0;
    base_set = 1'b0;
    cfg_win  = 32;
    cfg_tmo  = 50;
    cfg_first = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_order();
    test_timeout_extremes();
    test_window_extremes();
    test_random_settings();
    test_multicast_start();
    test_top_numbers();

    wait_drained();
    if (errors == 0) $display("PASS rlc_um_rx_reorder_window");
    else $display("FAIL rlc_um_rx_reorder_window");
    $finish;
  end

endmodule
